// File: hdl/jsu_pkg.sv
// Shared types, constants and helpers for the JSON string unescaper.
// Used by the hdl/ design files other than the two interfaces. No dependencies.
package jsu_pkg;

    localparam int unsigned RES_MAX   = 3;     // most results one request can cause
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned PTR_W     = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned RES_N_W   = $clog2(RES_MAX + 1);

    localparam logic [15:0] LIMIT_RESET = 16'd4090;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;

    localparam logic [15:0] UTF8_1B_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_2B_LIMIT = 16'h0800;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_HEX3   = 3'd4,
        MODE_HEX4   = 3'd5,
        MODE_DONE   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_QUOTE = 2'd0,
        CAUSE_TERM  = 2'd1,
        CAUSE_LIMIT = 2'd2
    } cause_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
        cause_t     end_cause;
    } res_t;

    // Bundle of results pushed into the result queue in one cycle.
    typedef struct packed {
        logic [RES_N_W-1:0] n;
        res_t [RES_MAX-1:0] res;
    } push_t;

    // Non-hex bytes count as zero.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

// File: hdl/jsu_in_if.sv
// Request channel into the unescaper: one raw string byte per request.
// Standalone; no package dependency.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface

// File: hdl/jsu_out_if.sv
// Result channel out of the unescaper: one decoded byte or status per result.
// Standalone; no package dependency.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_done;
    logic [1:0] end_cause;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output string_done, output end_cause, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input string_done, input end_cause, output ready);
endinterface

// File: hdl/jsu_decode.sv
// Parse state and single-pass decode of one registered input byte.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     byte_in,
    input  logic           first,
    input  logic [15:0]    limit,
    output jsu_pkg::push_t push
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    cp_reg, cp_next;
    logic [16:0]    cnt_reg, cnt_next;

    jsu_pkg::mode_t eff_mode;
    logic [15:0]    eff_cp;
    logic [16:0]    eff_cnt;
    logic [15:0]    cp_hex;
    logic [1:0]     cnt_add;

    // A first byte restarts the string before this byte is looked at.
    assign eff_mode = first ? jsu_pkg::MODE_NORMAL : mode_reg;
    assign eff_cp   = first ? 16'h0000 : cp_reg;
    assign eff_cnt  = first ? 17'h00000 : cnt_reg;
    assign cp_hex   = {eff_cp[11:0], jsu_pkg::hex_val(byte_in)};
    assign cnt_next = eff_cnt + {15'd0, cnt_add};

    // next state
    always_comb
    begin
        mode_next = eff_mode;
        cp_next   = eff_cp;
        case (eff_mode)
            jsu_pkg::MODE_NORMAL:
            begin
                if (byte_in == jsu_pkg::CH_NUL || byte_in == jsu_pkg::CH_QUOTE ||
                    eff_cnt >= {1'b0, limit})
                begin
                    mode_next = jsu_pkg::MODE_DONE;
                end
                else if (byte_in == jsu_pkg::CH_BSLASH)
                begin
                    mode_next = jsu_pkg::MODE_ESC;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (byte_in == jsu_pkg::CH_NUL)
                begin
                    mode_next = jsu_pkg::MODE_DONE;
                end
                else if (byte_in == jsu_pkg::CH_U)
                begin
                    mode_next = jsu_pkg::MODE_HEX1;
                    cp_next   = 16'h0000;
                end
                else
                begin
                    mode_next = jsu_pkg::MODE_NORMAL;
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX4:
            begin
                if (byte_in == jsu_pkg::CH_NUL)
                begin
                    mode_next = jsu_pkg::MODE_DONE;
                end
                else
                begin
                    cp_next = cp_hex;
                    if (eff_mode == jsu_pkg::MODE_HEX4)
                    begin
                        mode_next = jsu_pkg::MODE_NORMAL;
                    end
                    else
                    begin
                        mode_next = jsu_pkg::mode_t'(eff_mode + 3'd1);
                    end
                end
            end
            default:
            begin
                mode_next = eff_mode;   // done (and the unused code) sticks
            end
        endcase
    end

    // results
    always_comb
    begin
        push    = '0;
        cnt_add = 2'd0;
        case (eff_mode)
            jsu_pkg::MODE_NORMAL:
            begin
                if (byte_in == jsu_pkg::CH_NUL)
                begin
                    push.n                     = 2'd1;
                    push.res[0].string_done    = 1'b1;
                    push.res[0].end_cause      = jsu_pkg::CAUSE_TERM;
                end
                else if (eff_cnt >= {1'b0, limit})
                begin
                    push.n                     = 2'd1;
                    push.res[0].string_done    = 1'b1;
                    push.res[0].end_cause      = jsu_pkg::CAUSE_LIMIT;
                end
                else if (byte_in == jsu_pkg::CH_QUOTE)
                begin
                    push.n                     = 2'd1;
                    push.res[0].string_done    = 1'b1;
                    push.res[0].end_cause      = jsu_pkg::CAUSE_QUOTE;
                end
                else if (byte_in != jsu_pkg::CH_BSLASH)
                begin
                    push.n                  = 2'd1;
                    push.res[0].out_byte    = byte_in;
                    push.res[0].has_byte    = 1'b1;
                    cnt_add                 = 2'd1;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (byte_in != jsu_pkg::CH_U)
                begin
                    push.n               = 2'd1;
                    push.res[0].has_byte = 1'b1;
                    cnt_add              = 2'd1;
                    case (byte_in)
                        jsu_pkg::CH_NUL:
                        begin
                            // dangling backslash is kept and ends the string
                            push.res[0].out_byte    = jsu_pkg::CH_BSLASH;
                            push.res[0].string_done = 1'b1;
                            push.res[0].end_cause   = jsu_pkg::CAUSE_TERM;
                        end
                        jsu_pkg::CH_N: push.res[0].out_byte = jsu_pkg::BYTE_LF;
                        jsu_pkg::CH_R: push.res[0].out_byte = jsu_pkg::BYTE_CR;
                        jsu_pkg::CH_T: push.res[0].out_byte = jsu_pkg::BYTE_HT;
                        jsu_pkg::CH_B: push.res[0].out_byte = jsu_pkg::BYTE_BS;
                        jsu_pkg::CH_F: push.res[0].out_byte = jsu_pkg::BYTE_FF;
                        default:       push.res[0].out_byte = byte_in;
                    endcase
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX4:
            begin
                if (byte_in == jsu_pkg::CH_NUL)
                begin
                    push.n                  = 2'd1;
                    push.res[0].string_done = 1'b1;
                    push.res[0].end_cause   = jsu_pkg::CAUSE_TERM;
                end
                else if (eff_mode == jsu_pkg::MODE_HEX4)
                begin
                    push.res[0].has_byte = 1'b1;
                    push.res[1].has_byte = 1'b1;
                    push.res[2].has_byte = 1'b1;
                    if (cp_hex < jsu_pkg::UTF8_1B_LIMIT)
                    begin
                        push.n               = 2'd1;
                        cnt_add              = 2'd1;
                        push.res[0].out_byte = cp_hex[7:0];
                        push.res[1].has_byte = 1'b0;
                        push.res[2].has_byte = 1'b0;
                    end
                    else if (cp_hex < jsu_pkg::UTF8_2B_LIMIT)
                    begin
                        push.n               = 2'd2;
                        cnt_add              = 2'd2;
                        push.res[0].out_byte = {3'b110, cp_hex[10:6]};
                        push.res[1].out_byte = {2'b10, cp_hex[5:0]};
                        push.res[2].has_byte = 1'b0;
                    end
                    else
                    begin
                        push.n               = 2'd3;
                        cnt_add              = 2'd3;
                        push.res[0].out_byte = {4'b1110, cp_hex[15:12]};
                        push.res[1].out_byte = {2'b10, cp_hex[11:6]};
                        push.res[2].out_byte = {2'b10, cp_hex[5:0]};
                    end
                end
            end
            default:
            begin
                push.n = 2'd0;
            end
        endcase
        for (int i = 0; i < jsu_pkg::RES_MAX; i++)
        begin
            push.res[i].run_last = (push.n == jsu_pkg::RES_N_W'(i + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jsu_pkg::MODE_NORMAL;
            cp_reg   <= 16'h0000;
            cnt_reg  <= 17'h00000;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cp_reg   <= cp_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_done_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && push.n == 2'd1 && push.res[0].string_done)
        |=> (mode_reg == jsu_pkg::MODE_DONE))
        else $error("string end did not park the parser");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == jsu_pkg::MODE_DONE && !first) |-> (push.n == 2'd0))
        else $error("result produced after string end");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !first && eff_mode != jsu_pkg::MODE_DONE)
        |=> (cnt_reg - $past(cnt_reg) <= 17'd3))
        else $error("output count jumped");
`endif

endmodule

// File: hdl/jsu_result_fifo.sv
// Result queue: takes up to three results per cycle, delivers one per cycle when ready.
// Depends on jsu_pkg and jsu_out_if.
module jsu_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  jsu_pkg::push_t      push,
    output logic                room,
    jsu_out_if.source           out_ch
);

    jsu_pkg::res_t                  mem [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [jsu_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [jsu_pkg::RES_N_W-1:0]    n_push;
    logic                           pop;
    jsu_pkg::res_t                  head;

    assign n_push = push_en ? push.n : '0;
    assign pop    = out_ch.valid && out_ch.ready;
    // room for a full burst, regardless of this cycle's pop
    assign room   = count_reg <= jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH - jsu_pkg::RES_MAX);

    assign wr_ptr_next = wr_ptr_reg + jsu_pkg::PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + jsu_pkg::PTR_W'(pop);
    assign count_next  = count_reg + jsu_pkg::CNT_W'(n_push) - jsu_pkg::CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jsu_pkg::RES_MAX; i++)
        begin
            if (jsu_pkg::RES_N_W'(i) < n_push)
            begin
                mem[wr_ptr_reg + jsu_pkg::PTR_W'(i)] <= push.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head               = mem[rd_ptr_reg];
    assign out_ch.valid       = count_reg != '0;
    assign out_ch.out_byte    = head.out_byte;
    assign out_ch.has_byte    = head.has_byte;
    assign out_ch.run_last    = head.run_last;
    assign out_ch.string_done = head.string_done;
    assign out_ch.end_cause   = head.end_cause;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_en && push.n != '0) |-> room)
        else $error("push without room");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH))
        |-> (jsu_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[jsu_pkg::PTR_W-1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: hdl/json_string_unescaper.sv
// JSON string unescaper. Feed the bytes of a string body, one per request,
// starting right after the opening quote; set first_byte on the first byte
// of each string. Each request yields zero to three results: an escape
// prefix (backslash, or \u hex digits other than the last) yields none,
// a plain byte or simple escape yields one, and a \u escape yields its
// one to three UTF-8 bytes on the last hex digit. The string ends at the
// closing quote, a zero terminator, or when output_limit bytes have been
// emitted and a new element starts; the end is reported as a result with
// string_done set (carrying the backslash if one precedes the terminator).
// After the end, bytes are ignored until the next first_byte. run_last
// marks the final result of each request. The block takes a request every
// cycle unless stalled; a request is decoded while in the input register,
// its results enter an 8-entry result queue as it leaves that register,
// and they drain at one per cycle while the receiver is ready. Input
// stalls only while the input register holds a request and the queue has
// fewer than three free entries, so the sustained rate is set by the
// one-result-per-cycle output port. output_limit resets to 4090 and
// should be written only while idle.
module json_string_unescaper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    jsu_in_if.sink      in_ch,
    jsu_out_if.source   out_ch
);

    // output_limit register
    logic [15:0]    limit_reg;

    // input register stage
    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           first_reg;

    logic           in_accept;
    logic           room;
    logic           advance;
    jsu_pkg::push_t push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= jsu_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // The held request moves on once the queue can absorb a full burst.
    assign advance     = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || room;
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= in_ch.in_byte;
            first_reg   <= in_ch.first_byte;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (in_byte_reg),
        .first   (first_reg),
        .limit   (limit_reg),
        .push    (push)
    );

    jsu_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (push),
        .room    (room),
        .out_ch  (out_ch)
    );

`ifndef SYNTHESIS
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> (in_valid_reg && $stable(in_byte_reg)
                                     && $stable(first_reg)))
        else $error("held request lost while queue full");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty input register");

    a_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (limit_reg == $past(cfg_wr_data)))
        else $error("limit write not taken");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescaper: requests of raw string bytes in,
// decoded bytes and end-of-string status out. Depends on hdl/jsu_pkg.sv and the
// two channel interfaces; the expected results come from a local bit-true model.
module tb;
    import jsu_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 240;    // receiver back-pressure stretch
    localparam int SETTLE      = 6;      // wait after draining, with margin past the decode stage

    // One raw byte request as queued for the driver.
    typedef struct {
        logic [7:0] raw;
        logic       is_first;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = LIMIT_RESET;

    jsu_in_if  in_ch();
    jsu_out_if out_ch();

    json_string_unescaper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Stimulus and expectation stores.
    req_t raw_q[$];       // raw bytes waiting to be offered
    res_t decoded_q[$];   // results the model says must come out, oldest first

    int   n_sent = 0;     // requests queued, not counting junk after the end
    int   err_cnt = 0;
    logic start_flag = 1'b0;  // next queued byte opens a new string
    logic hold_go = 1'b0;     // asks the receiver for one long hold-off

    // ------------------------------------------------------------------
    // Model state: mirrors the block's parser, reset values at time zero.
    // ------------------------------------------------------------------
    mode_t       str_mode = MODE_NORMAL;
    logic [15:0] cp_acc = 16'h0000;     // \u digits gathered so far
    logic [16:0] byte_cnt = 17'd0;      // bytes emitted for this string
    logic [15:0] limit_reg = LIMIT_RESET;

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic void queue_result(logic [7:0] b, logic has, logic done, cause_t why);
        res_t r;
        r.out_byte    = has ? b : 8'h00;
        r.has_byte    = has;
        r.run_last    = 1'b0;
        r.string_done = done;
        r.end_cause   = done ? why : CAUSE_QUOTE;
        decoded_q.push_back(r);
        if (has)
        begin
            byte_cnt = byte_cnt + 17'd1;
        end
    endfunction

    function automatic void end_string(cause_t why);
        queue_result(8'h00, 1'b0, 1'b1, why);
        str_mode = MODE_DONE;
    endfunction

    function automatic void queue_utf8(logic [15:0] cp);
        if (cp < UTF8_1B_LIMIT)
        begin
            queue_result(cp[7:0], 1'b1, 1'b0, CAUSE_QUOTE);
        end
        else if (cp < UTF8_2B_LIMIT)
        begin
            queue_result({3'b110, cp[10:6]}, 1'b1, 1'b0, CAUSE_QUOTE);
            queue_result({2'b10, cp[5:0]}, 1'b1, 1'b0, CAUSE_QUOTE);
        end
        else
        begin
            queue_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, CAUSE_QUOTE);
            queue_result({2'b10, cp[11:6]}, 1'b1, 1'b0, CAUSE_QUOTE);
            queue_result({2'b10, cp[5:0]}, 1'b1, 1'b0, CAUSE_QUOTE);
        end
    endfunction

    // Decode one accepted request and append what it must produce.
    function automatic void unescape_byte(logic [7:0] b, logic is_first);
        int   n0;
        res_t tail;
        n0 = decoded_q.size();
        if (is_first)
        begin
            str_mode = MODE_NORMAL;
            cp_acc   = 16'h0000;
            byte_cnt = 17'd0;
        end
        case (str_mode)
            MODE_NORMAL:
            begin
                // terminator beats the limit; limit only checked at an element start
                if (b == CH_NUL)
                    end_string(CAUSE_TERM);
                else if (byte_cnt >= {1'b0, limit_reg})
                    end_string(CAUSE_LIMIT);
                else if (b == CH_QUOTE)
                    end_string(CAUSE_QUOTE);
                else if (b == CH_BSLASH)
                    str_mode = MODE_ESC;
                else
                    queue_result(b, 1'b1, 1'b0, CAUSE_QUOTE);
            end
            MODE_ESC:
            begin
                str_mode = MODE_NORMAL;
                case (b)
                    CH_NUL:
                    begin
                        // dangling backslash goes out with the end marker
                        queue_result(CH_BSLASH, 1'b1, 1'b1, CAUSE_TERM);
                        str_mode = MODE_DONE;
                    end
                    CH_N: queue_result(BYTE_LF, 1'b1, 1'b0, CAUSE_QUOTE);
                    CH_R: queue_result(BYTE_CR, 1'b1, 1'b0, CAUSE_QUOTE);
                    CH_T: queue_result(BYTE_HT, 1'b1, 1'b0, CAUSE_QUOTE);
                    CH_B: queue_result(BYTE_BS, 1'b1, 1'b0, CAUSE_QUOTE);
                    CH_F: queue_result(BYTE_FF, 1'b1, 1'b0, CAUSE_QUOTE);
                    CH_U:
                    begin
                        cp_acc   = 16'h0000;
                        str_mode = MODE_HEX1;
                    end
                    default: queue_result(b, 1'b1, 1'b0, CAUSE_QUOTE);
                endcase
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
            begin
                if (b == CH_NUL)
                begin
                    // escape cut short: drop it, end on the terminator
                    end_string(CAUSE_TERM);
                end
                else
                begin
                    cp_acc = {cp_acc[11:0], hex_nibble(b)};
                    if (str_mode == MODE_HEX4)
                    begin
                        str_mode = MODE_NORMAL;
                        queue_utf8(cp_acc);
                    end
                    else
                    begin
                        str_mode = mode_t'(str_mode + 3'd1);
                    end
                end
            end
            default: ;  // finished string: byte ignored
        endcase
        if (decoded_q.size() > n0)
        begin
            tail = decoded_q.pop_back();
            tail.run_last = 1'b1;
            decoded_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void push_req(logic [7:0] b);
        req_t r;
        r.raw      = b;
        r.is_first = start_flag;
        start_flag = 1'b0;
        raw_q.push_back(r);
        n_sent++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_req(s[i]);
    endfunction

    // Hex digit with random case; now and then a byte that is not hex at all.
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(1, 255));
        if (n < 4'd10)
            return "0" + 8'(n);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    // Code point spread over the 1, 2 and 3 byte UTF-8 ranges and their edges.
    function automatic logic [15:0] pick_code_point();
        logic [15:0] edges[6];
        edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            default: return edges[$urandom_range(0, 5)];
        endcase
    endfunction

    // One string body: mostly well-formed elements, some noise, a random ending.
    function automatic void gen_string(int n_elem);
        logic [7:0]  esc_set[8];
        logic [7:0]  c;
        logic [15:0] cp;
        int          kind;
        req_t        junk;
        esc_set = '{CH_QUOTE, CH_BSLASH, "/", CH_N, CH_R, CH_T, CH_B, CH_F};
        // rarely leave first_byte low so the bytes run on in the old state
        start_flag = ($urandom_range(0, 19) != 0);
        repeat (n_elem)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = "a";
                push_req(c);
            end
            else if (kind < 60)
            begin
                push_req(CH_BSLASH);
                push_req(esc_set[$urandom_range(0, 7)]);
            end
            else if (kind < 67)
            begin
                // unknown escape is copied through
                c = 8'($urandom_range(1, 255));
                if (c == CH_U)
                    c = "x";
                push_req(CH_BSLASH);
                push_req(c);
            end
            else if (kind < 95)
            begin
                push_req(CH_BSLASH);
                push_req(CH_U);
                cp = pick_code_point();
                for (int i = 3; i >= 0; i--)
                    push_req(hex_char(cp[i*4 +: 4]));
            end
            else
            begin
                push_req(8'($urandom_range(0, 255)));
            end
        end
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            push_req(CH_QUOTE);
        end
        else if (kind < 80)
        begin
            push_req(CH_NUL);
        end
        else if (kind < 88)
        begin
            push_req(CH_BSLASH);
            push_req(CH_NUL);
        end
        else if (kind < 96)
        begin
            push_req(CH_BSLASH);
            push_req(CH_U);
            repeat ($urandom_range(0, 3))
                push_req(hex_char(4'($urandom_range(0, 15))));
            push_req(CH_NUL);
        end
        // otherwise left open; the next string restarts it if it sets first_byte
        if ($urandom_range(0, 3) == 0)
        begin
            junk.raw      = 8'($urandom_range(0, 255));
            junk.is_first = 1'b0;
            raw_q.push_back(junk);
        end
    endfunction

    function automatic void gen_strings(int n_items, int max_elem);
        int target;
        target = n_sent + n_items;
        while (n_sent < target)
            gen_string($urandom_range(1, max_elem));
    endfunction

    // Wait in cycles after each handshake, with occasional runs of back-to-back traffic.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            run_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers queued bytes, predicts on each handshake.
    // ------------------------------------------------------------------
    int send_gap = 0;
    int send_run = 0;

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        req_t nxt;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.in_byte    <= 8'h00;
            in_ch.first_byte <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                unescape_byte(in_ch.in_byte, in_ch.first_byte);
            // slot is free once the current request is taken or none is up
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (raw_q.size() != 0)
                begin
                    nxt = raw_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.in_byte    <= nxt.raw;
                    in_ch.first_byte <= nxt.is_first;
                    send_gap = draw_wait(send_run);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares each result with the oldest expectation and
    // paces ready, including one long hold-off to fill the result queue.
    // ------------------------------------------------------------------
    int   take_gap = 0;
    int   take_run = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    task automatic report_mismatch(string what, res_t got, res_t want);
        $display("MISMATCH @%0t %s: ", $realtime, what,
                 "got byte=%02h has=%0d last=%0d done=%0d cause=%0d, ",
                 got.out_byte, got.has_byte, got.run_last, got.string_done, got.end_cause,
                 "want byte=%02h has=%0d last=%0d done=%0d cause=%0d",
                 want.out_byte, want.has_byte, want.run_last, want.string_done,
                 want.end_cause);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_gap  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.out_byte    = out_ch.out_byte;
                got.has_byte    = out_ch.has_byte;
                got.run_last    = out_ch.run_last;
                got.string_done = out_ch.string_done;
                got.end_cause   = cause_t'(out_ch.end_cause);
                if (decoded_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending", got, '0);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                        got.run_last !== want.run_last ||
                        got.string_done !== want.string_done ||
                        got.end_cause !== want.end_cause)
                        report_mismatch("wrong result", got, want);
                end
                take_gap = draw_wait(take_run);
            end
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phase control. The sender pauses at every phase boundary until all
    // pending results are back, then the limit register is rewritten.
    // ------------------------------------------------------------------
    task automatic drain();
        do
            @(negedge clk);
        while (raw_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
        // a trailing byte with no result may still sit in the decode stage
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, limit at its reset value.
        // Bytes before any first_byte decode as a string body.
        start_flag = 1'b0;
        push_text("A");
        push_req(8'h01);
        push_req(8'hFF);
        push_text("\\t\\u07fF\"");         // simple escape, two-byte UTF-8, quote end
        start_flag = 1'b1;
        push_text("\\uFfgZ\\q\\");         // bad hex digits as zero, unknown escape
        push_req(CH_NUL);                  // backslash then terminator
        start_flag = 1'b1;
        push_text("\\u1");
        push_req(CH_NUL);                  // \u escape cut short
        push_text("x");                    // ignored after the end
        start_flag = 1'b1;
        push_req(CH_NUL);                  // empty string, terminator only
        drain();

        // Limit zero: every string ends on its first element; NUL still wins.
        set_limit(16'd0);
        start_flag = 1'b1;
        push_text("a");
        start_flag = 1'b1;
        push_req(CH_NUL);
        gen_strings(25, 3);
        drain();

        // Largest limit, with a long receiver stall while requests keep coming.
        set_limit(16'hFFFF);
        gen_strings(130, 10);
        @(posedge clk);
        hold_go <= 1'b1;
        @(negedge clk);
        drain();

        // Limits of one, two and a small random one: escapes overrun them by up to two.
        set_limit(16'd1);
        gen_strings(50, 6);
        drain();
        set_limit(16'd2);
        start_flag = 1'b1;
        push_text("\\u0800z");
        gen_strings(80, 8);
        drain();
        set_limit(16'($urandom_range(3, 12)));
        gen_strings(80, 10);
        drain();

        // Random limit, then back to the reset value.
        set_limit(16'($urandom_range(0, 16'hFFFF)));
        gen_strings(70, 10);
        drain();
        set_limit(LIMIT_RESET);
        gen_strings(70, 10);
        drain();

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_decode.sv
hdl/jsu_result_fifo.sv
hdl/json_string_unescaper.sv
test/tb.sv
